>>> hdl/bai_pkg.sv
// bai_pkg: shared constants and codes for the bitmap ID allocator
// map word geometry, field widths, request and status codes, register map
// depends on nothing; imported by bitmap_id_allocator
`timescale 1ns / 1ps
`default_nettype none

package bai_pkg;

  // default capacity of the ID space
  localparam int DEF_MAX_IDS = 1024;

  // used-map word held in one memory row
  localparam int WORD_W = 64;
  localparam int BIT_W  = $clog2(WORD_W);

  // fixed field widths
  localparam int ID_W       = 10;
  localparam int CNT_W      = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register reset values
  localparam logic             USE_IDS_RST  = 1'b1;
  localparam logic [CNT_W-1:0] ID_COUNT_RST = 11'd1024;

  // register select, taken from address bit 2
  localparam logic REG_USE_IDS  = 1'b0;
  localparam logic REG_ID_COUNT = 1'b1;

  // request codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RANGE = 2'd1,
    OP_FREE  = 2'd2
  } opcode_t;

  // answer codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_INVALID = 2'd2,
    STS_NOTSUP  = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> hdl/bai_ram.sv
// bai_ram: generic single-write, single-read RAM with registered read data
// used to hold the used-map rows of the allocator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module bai_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/bitmap_id_allocator.sv
// bitmap_id_allocator: ID allocator over a used-bitmap with first-free search
// request sequencer, shared 64-bit word search unit, APB register port
// depends on bai_pkg and bai_ram
//
// Usage
//   in_*   : one request per transfer; in_tuser carries the opcode
//            (allocate, allocate within range, free), in_tdata the arguments
//   out_*  : exactly one answer per request, in request order; held in an
//            output register until out_tready takes it
//   cfg_*  : APB port, use_ids at 0x0, id_count at 0x4, pready always high
// Timing
//   the used-map lives in a RAM of 64-bit rows; the search unit looks at one
//   row per cycle; an allocation scans rows until it finds a free bit or
//   reaches the last row of the count; a free reads its row and clears the
//   bit; answers decided from the arguments alone do not touch the map
//   one request is in work at a time; in_tready is high only when idle
// Reset
//   rst_n is synchronous; after it the map is cleared one row per cycle,
//   all ceil(MAX_IDS/64) rows (16 at the default), with IDs 0 and 1 marked
//   used, and no request is taken meanwhile; config writes are always taken
// Stall
//   while out_tready is low, a finished answer waits in the output stage
//   and the next answer waits in the sequencer, so nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module bitmap_id_allocator
  import bai_pkg::*;
#(
  parameter int MAX_IDS = DEF_MAX_IDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [9:0] range_min, [19:10] range_max, [29:20] free_id, [31:30] zero
  input  wire logic [31:0]           in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]            in_tuser,
  // answer channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [9:0] allocated_id, [11:10] status, [12] double_free, [15:13] zero
  output logic      [15:0]           out_tdata,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int ROWS  = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (ROW_W + BIT_W + 1 > CNT_W) ? ROW_W + BIT_W + 1 : CNT_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FREE  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // lowest set bit of a word, with a hit flag on top
  function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             first_r, first_nxt;
  logic             is_range_r, is_range_nxt;
  logic [BIT_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]    rmax_r, rmax_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  status_t          res_sts_r, res_sts_nxt;
  logic             res_dbl_r, res_dbl_nxt;

  logic             use_ids_r;
  logic [CNT_W-1:0] id_count_r;

  logic             out_tvalid_r;
  logic [15:0]      out_tdata_r;

  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]    eff_cnt, cnt_m1, rmin_w, rmax_w, fid_w, found_w;
  logic             alloc_on;
  logic [ROW_W-1:0] last_row;
  logic [BIT_W-1:0] last_bit;
  logic [WORD_W-1:0] lo_mask, hi_mask, cand;
  logic [BIT_W:0]   ffs;
  logic             out_load;

  // configuration registers
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_ids_r  <= USE_IDS_RST;
      id_count_r <= ID_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_USE_IDS:  use_ids_r  <= cfg_pwdata[0];
        REG_ID_COUNT: id_count_r <= cfg_pwdata[CNT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_USE_IDS:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, use_ids_r};
      REG_ID_COUNT: cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, id_count_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // effective count and scan limits
  assign eff_cnt  = (CW'(id_count_r) > CW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(id_count_r);
  assign alloc_on = use_ids_r && (eff_cnt > CW'(1));
  assign cnt_m1   = eff_cnt - CW'(1);
  assign last_row = ROW_W'(cnt_m1 >> BIT_W);
  assign last_bit = cnt_m1[BIT_W-1:0];

  // request arguments
  assign rmin_w = CW'(in_tdata[9:0]);
  assign rmax_w = CW'(in_tdata[19:10]);
  assign fid_w  = CW'(in_tdata[29:20]);

  // shared word search unit: free bits of the current row inside the window
  assign lo_mask = first_r ? ({WORD_W{1'b1}} << pos_r) : {WORD_W{1'b1}};
  assign hi_mask = (row_r == last_row) ? ({WORD_W{1'b1}} >> (~last_bit))
                                       : {WORD_W{1'b1}};
  assign cand    = ~ram_rdata & lo_mask & hi_mask;
  assign ffs     = first_set(cand);
  assign found_w = CW'({row_r, ffs[BIT_W-1:0]});

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // request sequencer
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    first_nxt    = first_r;
    is_range_nxt = is_range_r;
    pos_nxt      = pos_r;
    rmax_nxt     = rmax_r;
    res_id_nxt   = res_id_r;
    res_sts_nxt  = res_sts_r;
    res_dbl_nxt  = res_dbl_r;
    ram_we       = 1'b0;
    ram_waddr    = row_r;
    ram_wdata    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (row_r == '0) ? {{(WORD_W-2){1'b0}}, 2'b11} : '0;
        row_nxt   = ROW_W'(row_r + 1'b1);
        if (row_r == ROW_W'(ROWS - 1)) begin
          row_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          res_id_nxt   = '0;
          res_sts_nxt  = STS_OK;
          res_dbl_nxt  = 1'b0;
          first_nxt    = 1'b1;
          is_range_nxt = 1'b0;
          pos_nxt      = '0;
          rmax_nxt     = rmax_w;
          row_nxt      = '0;
          state_nxt    = ST_DONE;
          unique case (in_tuser)
            OP_ALLOC: begin
              if (!alloc_on) begin
                res_id_nxt = ID_W'(1);
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_RANGE: begin
              priority if (rmin_w >= eff_cnt) begin
                res_sts_nxt = STS_INVALID;
              end else if (!alloc_on) begin
                res_sts_nxt = STS_NOTSUP;
              end else begin
                is_range_nxt = 1'b1;
                row_nxt      = ROW_W'(rmin_w >> BIT_W);
                pos_nxt      = rmin_w[BIT_W-1:0];
                state_nxt    = ST_SCAN;
              end
            end
            OP_FREE: begin
              priority if (fid_w == '0) begin
                res_sts_nxt = STS_INVALID;
              end else if (!alloc_on || fid_w == CW'(1)) begin
                res_sts_nxt = STS_OK;
              end else if (fid_w >= eff_cnt) begin
                res_sts_nxt = STS_INVALID;
              end else begin
                row_nxt   = ROW_W'(fid_w >> BIT_W);
                pos_nxt   = fid_w[BIT_W-1:0];
                state_nxt = ST_FREE;
              end
            end
            default: res_sts_nxt = STS_INVALID;
          endcase
        end
      end
      ST_SCAN: begin
        first_nxt = 1'b0;
        priority if (ffs[BIT_W]) begin
          state_nxt = ST_DONE;
          if (is_range_r && found_w > rmax_r) begin
            res_sts_nxt = STS_NOSPACE;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata | (WORD_W'(1) << ffs[BIT_W-1:0]);
            res_id_nxt = found_w[ID_W-1:0];
          end
        end else if (row_r == last_row) begin
          res_sts_nxt = STS_NOSPACE;
          state_nxt   = ST_DONE;
        end else begin
          row_nxt = ROW_W'(row_r + 1'b1);
        end
      end
      ST_FREE: begin
        ram_we      = 1'b1;
        ram_wdata   = ram_rdata & ~(WORD_W'(1) << pos_r);
        res_dbl_nxt = ~ram_rdata[pos_r];
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      first_r <= first_nxt;
    end
  end

  // request context and pending answer
  always_ff @(posedge clk) begin
    is_range_r <= is_range_nxt;
    pos_r      <= pos_nxt;
    rmax_r     <= rmax_nxt;
    res_id_r   <= res_id_nxt;
    res_sts_r  <= res_sts_nxt;
    res_dbl_r  <= res_dbl_nxt;
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {3'b000, res_dbl_r, res_sts_r, res_id_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // used-map storage, one 64-bit row per entry
  bai_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row_nxt),
    .rdata (ram_rdata)
  );

  // no request taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("request taken while map is being cleared");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  // the scan never walks past the last row of the count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (row_r <= last_row))
    else $error("scan beyond last row");

  // map is only written while clearing, scanning or freeing
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_SCAN || state_r == ST_FREE))
    else $error("map written outside an update step");

  // a double free answer carries no ID and status ok
  a_dbl_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |-> (out_tdata[11:0] == 12'd0))
    else $error("double free answer with ID or error status");

endmodule

`default_nettype wire
